// File: rtl/assert_macros.svh
// Assertion helpers for the sphere cell generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define UVS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UVS_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define UVS_ASSERT(label, prop, msg)
`define UVS_NEVER(label, expr, msg)
`endif
`endif

// File: rtl/uvs_pkg.sv
`timescale 1ns / 1ps
package uvs_pkg;
  localparam int MAX_DIVISIONS = 1024;
  localparam int FRACTION_BITS = 14;
  localparam int N_W = 11;
  localparam int STEP_W = 12;
  localparam int REM_W = 11;
  localparam int ANG_W = 32;
  localparam int NUM_W = 2 * REM_W;
  localparam int CORDIC_STEPS = 24;
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam int POS_W = 16;
  localparam int VN_W = 24;
  localparam int ANG_LAT = 5;
  localparam int COR_LAT = CORDIC_STEPS + 1;
  localparam int PIPE_LAT = ANG_LAT + COR_LAT + 2;
  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
  localparam logic [ANG_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };
  localparam logic [2:0] LAST_K = 3'd5;

  typedef enum logic [7:0] {
    CFG_THETA_DIVISIONS   = 8'd0,
    CFG_DOUBLED_LONGITUDE = 8'd1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [ANG_W-1:0] t_quo;
    logic [REM_W-1:0] t_rem;
    logic [ANG_W-1:0] p_quo;
    logic [REM_W-1:0] p_rem;
  } rcp_t;

  // p0 p1 p2 p2 p3 p0
  function automatic logic [1:0] pt_sel(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd1, 3'd4: r = 2'd1;
      3'd2, 3'd5: r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction
endpackage

// File: rtl/uvs_if.sv
`timescale 1ns / 1ps
interface uvs_in_if;
  import uvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [9:0]       theta_step;
  logic [N_W-1:0]   phi_step;
  modport source (output valid, theta_step, phi_step, input ready);
  modport sink (input valid, theta_step, phi_step, output ready);
endinterface

interface uvs_out_if;
  import uvs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [1:0]              corner;
  logic [VN_W-1:0]         vertex_number;
  logic                    range_error;
  logic                    last;
  modport source (output valid, pos_x, pos_y, pos_z, corner, vertex_number, range_error,
                  last, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, corner, vertex_number, range_error,
                last, output ready);
endinterface

interface uvs_cfg_if;
  import uvs_pkg::*;
  logic           valid;
  logic           ready;
  logic [7:0]     index;
  logic [N_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/uvs_recip.sv
`timescale 1ns / 1ps
module uvs_recip (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [10:0]        tden,
  input  logic [10:0]        pden,
  output uvs_pkg::rcp_t      rcp,
  output logic               busy
);
  import uvs_pkg::*;

  localparam logic [5:0] LAST_CNT = 6'(ANG_W);

  logic [5:0]       cnt_r;
  logic             busy_r;
  logic [REM_W-1:0] trem_r, prem_r;
  logic [ANG_W-1:0] tquo_r, pquo_r;
  logic [REM_W:0]   tstep, pstep;
  logic             dbit;

  // 2^32 / den, one quotient bit a cycle while busy
  function automatic logic [REM_W:0] dstep(input logic [REM_W-1:0] rem, input logic b,
                                           input logic [REM_W-1:0] den);
    logic [REM_W:0] r2;
    r2 = {rem, b};
    if (r2 >= {1'b0, den}) begin
      r2 = r2 - {1'b0, den};
      return {1'b1, r2[REM_W-1:0]};
    end
    return {1'b0, r2[REM_W-1:0]};
  endfunction

  assign dbit  = (cnt_r == '0);
  assign tstep = dstep(trem_r, dbit, tden);
  assign pstep = dstep(prem_r, dbit, pden);

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      trem_r <= '0;
      prem_r <= '0;
      tquo_r <= '0;
      pquo_r <= '0;
    end else if (busy_r) begin
      trem_r <= tstep[REM_W-1:0];
      prem_r <= pstep[REM_W-1:0];
      tquo_r <= {tquo_r[ANG_W-2:0], tstep[REM_W]};
      pquo_r <= {pquo_r[ANG_W-2:0], pstep[REM_W]};
      cnt_r  <= cnt_r + 6'd1;
      if (cnt_r == LAST_CNT) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign rcp.t_quo = tquo_r;
  assign rcp.t_rem = trem_r;
  assign rcp.p_quo = pquo_r;
  assign rcp.p_rem = prem_r;
  assign busy      = busy_r;
endmodule

// File: rtl/uvs_angle.sv
`timescale 1ns / 1ps
module uvs_angle (
  input  logic                         clk,
  input  logic                         en,
  input  uvs_pkg::rcp_t                rcp,
  input  logic [10:0]                  tden,
  input  logic [10:0]                  pden,
  input  logic [9:0]                   theta_step,
  input  logic [10:0]                  phi_step,
  output logic [3:0][31:0]             ang
);
  import uvs_pkg::*;

  logic [STEP_W-1:0] step [4];
  logic [REM_W-1:0]  den  [4];
  logic [ANG_W-1:0]  quo  [4];
  logic [REM_W-1:0]  rem  [4];
  logic [NUM_W-1:0]  r_w  [4];
  logic [ANG_W-1:0]  sq_w [4];

  logic [ANG_W-1:0]  sq_r  [4][4];
  logic [REM_W-1:0]  rem_r [4][4];
  logic [REM_W-1:0]  num_r [4][4];
  logic [REM_W-1:0]  q_r   [4][4];
  logic [REM_W-1:0]  rem_w [4][4];
  logic [REM_W-1:0]  num_w [4][4];
  logic [REM_W-1:0]  q_w   [4][4];
  logic [ANG_W-1:0]  ang_r [4];

  // angle = step*floor(2^32/den) + round((step*(2^32 mod den)) / den)
  always_comb begin
    step[0] = STEP_W'(theta_step);
    step[1] = STEP_W'(theta_step) + 12'd1;
    step[2] = STEP_W'(phi_step);
    step[3] = STEP_W'(phi_step) + 12'd1;
    den[0]  = tden;
    den[1]  = tden;
    den[2]  = pden;
    den[3]  = pden;
    quo[0]  = rcp.t_quo;
    quo[1]  = rcp.t_quo;
    quo[2]  = rcp.p_quo;
    quo[3]  = rcp.p_quo;
    rem[0]  = rcp.t_rem;
    rem[1]  = rcp.t_rem;
    rem[2]  = rcp.p_rem;
    rem[3]  = rcp.p_rem;
    for (int l = 0; l < 4; l++) begin
      r_w[l]  = NUM_W'(23'(step[l]) * 23'(rem[l]) + 23'(den[l] >> 1));
      sq_w[l] = ANG_W'(step[l]) * quo[l];
    end
  end

  always_comb begin
    logic [REM_W-1:0] rm, nm, qq;
    logic [REM_W:0]   r2;
    logic             qb;
    for (int s = 0; s < 4; s++) begin
      for (int l = 0; l < 4; l++) begin
        rem_w[s][l] = '0;
        num_w[s][l] = '0;
        q_w[s][l]   = '0;
      end
    end
    for (int s = 1; s < 4; s++) begin
      for (int l = 0; l < 4; l++) begin
        rm = rem_r[s-1][l];
        nm = num_r[s-1][l];
        qq = q_r[s-1][l];
        for (int i = 0; i < 4; i++) begin
          if ((s - 1) * 4 + i < REM_W) begin
            r2 = {rm, nm[REM_W-1]};
            nm = {nm[REM_W-2:0], 1'b0};
            qb = 1'b0;
            if (r2 >= {1'b0, den[l]}) begin
              r2 = r2 - {1'b0, den[l]};
              qb = 1'b1;
            end
            rm = r2[REM_W-1:0];
            qq = {qq[REM_W-2:0], qb};
          end
        end
        rem_w[s][l] = rm;
        num_w[s][l] = nm;
        q_w[s][l]   = qq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        sq_r[0][l]  <= sq_w[l];
        rem_r[0][l] <= r_w[l][NUM_W-1:REM_W];
        num_r[0][l] <= r_w[l][REM_W-1:0];
        q_r[0][l]   <= '0;
        for (int s = 1; s < 4; s++) begin
          sq_r[s][l]  <= sq_r[s-1][l];
          rem_r[s][l] <= rem_w[s][l];
          num_r[s][l] <= num_w[s][l];
          q_r[s][l]   <= q_w[s][l];
        end
        ang_r[l] <= sq_r[3][l] + ANG_W'(q_r[3][l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ang[l] = ang_r[l];
    end
  end
endmodule

// File: rtl/uvs_cordic.sv
`timescale 1ns / 1ps
module uvs_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        angle,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);
  import uvs_pkg::*;

  localparam int LAST = CORDIC_STEPS - 1;

  logic signed [CW-1:0] x_r [CORDIC_STEPS];
  logic signed [CW-1:0] y_r [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS];
  logic [1:0]           qd_r [CORDIC_STEPS];
  logic signed [CW-1:0] xi [CORDIC_STEPS];
  logic signed [CW-1:0] yi [CORDIC_STEPS];
  logic signed [ZW-1:0] zi [CORDIC_STEPS];
  logic [1:0]           qi [CORDIC_STEPS];
  logic signed [CW-1:0] xn [CORDIC_STEPS];
  logic signed [CW-1:0] yn [CORDIC_STEPS];
  logic signed [ZW-1:0] zn [CORDIC_STEPS];
  logic signed [31:0]   cos_r, sin_r;

  always_comb begin
    xi[0] = CORDIC_START;
    yi[0] = '0;
    zi[0] = signed'(ZW'(angle[29:0]));
    qi[0] = angle[31:30];
    for (int k = 1; k < CORDIC_STEPS; k++) begin
      xi[k] = x_r[k-1];
      yi[k] = y_r[k-1];
      zi[k] = z_r[k-1];
      qi[k] = qd_r[k-1];
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (!zi[k][ZW-1]) begin
        xn[k] = xi[k] - (yi[k] >>> k);
        yn[k] = yi[k] + (xi[k] >>> k);
        zn[k] = zi[k] - signed'(ZW'(ATAN_TURNS[k]));
      end else begin
        xn[k] = xi[k] + (yi[k] >>> k);
        yn[k] = yi[k] - (xi[k] >>> k);
        zn[k] = zi[k] + signed'(ZW'(ATAN_TURNS[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        x_r[k]  <= xn[k];
        y_r[k]  <= yn[k];
        z_r[k]  <= zn[k];
        qd_r[k] <= qi[k];
      end
      case (qd_r[LAST])
        2'd0: begin
          cos_r <= 32'(x_r[LAST]);
          sin_r <= 32'(y_r[LAST]);
        end
        2'd1: begin
          cos_r <= 32'(-y_r[LAST]);
          sin_r <= 32'(x_r[LAST]);
        end
        2'd2: begin
          cos_r <= 32'(-x_r[LAST]);
          sin_r <= 32'(-y_r[LAST]);
        end
        default: begin
          cos_r <= 32'(y_r[LAST]);
          sin_r <= 32'(-x_r[LAST]);
        end
      endcase
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;
endmodule

// File: rtl/uvs_ser.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module uvs_ser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load_vld,
  input  uvs_pkg::point_t [3:0]     pts,
  input  logic                      err,
  input  logic [23:0]               base,
  output logic                      ready,
  uvs_out_if.source                 out_ch
);
  import uvs_pkg::*;

  point_t [3:0]    pt_r;
  logic            err_r;
  logic [VN_W-1:0] base_r;
  logic [2:0]      k_r;
  logic            vld_r;
  logic            last_w;
  logic            fire;
  point_t          cur;

  assign last_w = err_r || (k_r == LAST_K);
  assign fire   = vld_r && out_ch.ready;
  assign ready  = !vld_r || (fire && last_w);
  assign cur    = pt_r[pt_sel(k_r)];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      k_r   <= '0;
    end else if (load_vld && ready) begin
      vld_r <= 1'b1;
      k_r   <= '0;
    end else if (fire) begin
      if (last_w) begin
        vld_r <= 1'b0;
      end else begin
        k_r <= k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_vld && ready) begin
      pt_r   <= pts;
      err_r  <= err;
      base_r <= base;
    end
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.pos_x         = err_r ? '0 : cur.x;
  assign out_ch.pos_y         = err_r ? '0 : cur.y;
  assign out_ch.pos_z         = err_r ? '0 : cur.z;
  assign out_ch.corner        = err_r ? 2'd0 : corner_of(k_r);
  assign out_ch.vertex_number = err_r ? '0 : base_r + VN_W'(k_r);
  assign out_ch.range_error   = err_r;
  assign out_ch.last          = last_w;

  `UVS_ASSERT(a_k_advance, fire && !last_w |=> vld_r && (k_r == $past(k_r) + 3'd1), "k skip")
  `UVS_NEVER(a_err_single, vld_r && err_r && (k_r != 3'd0), "error word past first")
  `UVS_NEVER(a_k_max, vld_r && (k_r > LAST_K), "vertex count overrun")
endmodule

// File: rtl/uv_sphere_cell_vertex_generator_core.sv
`timescale 1ns / 1ps
// Each accepted cell gives six vertex words (out-of-range cells: one error word);
// new cells are taken while earlier ones are still in flight, unless the output stalls.
// Pipeline: 5 angle stages, 25 CORDIC stages, product and rounding stages.
// Reset (rst_n low, synchronous): N=16, single longitude; then a reciprocal
// pass runs with in ready low, and again after every config write.
`include "assert_macros.svh"
module uv_sphere_cell_vertex_generator_core (
  input  logic       clk,
  input  logic       rst_n,
  uvs_in_if.sink     in_ch,
  uvs_out_if.source  out_ch,
  uvs_cfg_if.sink    cfg_ch
);
  import uvs_pkg::*;

  localparam int RND_SH = 60 - FRACTION_BITS;
  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (RND_SH - 1);
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRACTION_BITS;

  logic [N_W-1:0]  theta_div_r;
  logic            dbl_r;
  logic [N_W-1:0]  n_eff;
  logic [N_W:0]    m_eff;
  logic [N_W-1:0]  tden, pden;
  logic            cfg_wr;
  rcp_t            rcp;
  logic            rcp_busy;
  logic            pipe_en;
  logic            in_acc;
  logic            err_w;
  logic [VN_W-1:0] base_w;
  logic [3:0][31:0] ang;
  logic signed [31:0] cos_w [4];
  logic signed [31:0] sin_w [4];
  logic signed [63:0] px_r [4];
  logic signed [63:0] py_r [4];
  logic signed [31:0] pz_r [4];
  point_t [3:0]    pt_r;
  logic            sb_vld_r  [PIPE_LAT];
  logic            sb_err_r  [PIPE_LAT];
  logic [VN_W-1:0] sb_base_r [PIPE_LAT];
  logic            ser_ready;

  function automatic logic signed [POS_W-1:0] rnd_sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + RND_HALF) >>> RND_SH;
    if (r > ONE) begin
      r = ONE;
    end else if (r < -ONE) begin
      r = -ONE;
    end
    return POS_W'(r);
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_div_r <= 11'd16;
      dbl_r       <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_ch.index)
        CFG_THETA_DIVISIONS:   theta_div_r <= cfg_ch.data;
        CFG_DOUBLED_LONGITUDE: dbl_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign n_eff = (theta_div_r > N_W'(MAX_DIVISIONS)) ? N_W'(MAX_DIVISIONS) : theta_div_r;
  assign m_eff = dbl_r ? {n_eff, 1'b0} : {1'b0, n_eff};
  assign tden  = N_W'((n_eff - 11'd1) << 1);
  assign pden  = N_W'(m_eff - 12'd1);

  uvs_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr),
    .tden  (tden),
    .pden  (pden),
    .rcp   (rcp),
    .busy  (rcp_busy)
  );

  assign pipe_en     = !sb_vld_r[PIPE_LAT-1] || ser_ready;
  assign in_ch.ready = pipe_en && !rcp_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign err_w  = (n_eff < 11'd2) || (N_W'(in_ch.theta_step) >= N_W'(n_eff - 11'd1)) ||
                  (in_ch.phi_step >= pden);
  assign base_w = VN_W'((VN_W'(in_ch.theta_step) * VN_W'(pden) + VN_W'(in_ch.phi_step))
                        * 24'd6);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        sb_vld_r[i] <= 1'b0;
      end
    end else if (pipe_en) begin
      sb_vld_r[0] <= in_acc;
      for (int i = 1; i < PIPE_LAT; i++) begin
        sb_vld_r[i] <= sb_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sb_err_r[0]  <= err_w;
      sb_base_r[0] <= base_w;
      for (int i = 1; i < PIPE_LAT; i++) begin
        sb_err_r[i]  <= sb_err_r[i-1];
        sb_base_r[i] <= sb_base_r[i-1];
      end
    end
  end

  uvs_angle u_angle (
    .clk        (clk),
    .en         (pipe_en),
    .rcp        (rcp),
    .tden       (tden),
    .pden       (pden),
    .theta_step (in_ch.theta_step),
    .phi_step   (in_ch.phi_step),
    .ang        (ang)
  );

  // lanes: theta0, theta1, phi0, phi1
  for (genvar g = 0; g < 4; g++) begin : g_cordic
    uvs_cordic u_cordic (
      .clk   (clk),
      .en    (pipe_en),
      .angle (ang[g]),
      .cos_q (cos_w[g]),
      .sin_q (sin_w[g])
    );
  end

  // p0 (t0,f0) p1 (t1,f0) p2 (t1,f1) p3 (t0,f1)
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int p = 0; p < 4; p++) begin
        px_r[p] <= 64'(sin_w[(p == 1 || p == 2) ? 1 : 0]) * 64'(cos_w[(p < 2) ? 2 : 3]);
        py_r[p] <= 64'(sin_w[(p == 1 || p == 2) ? 1 : 0]) * 64'(sin_w[(p < 2) ? 2 : 3]);
        pz_r[p] <= cos_w[(p == 1 || p == 2) ? 1 : 0];
        pt_r[p].x <= rnd_sat(px_r[p]);
        pt_r[p].y <= rnd_sat(py_r[p]);
        pt_r[p].z <= rnd_sat(signed'({pz_r[p], 32'd0}) >>> 2);
      end
    end
  end

  uvs_ser u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_vld (sb_vld_r[PIPE_LAT-1]),
    .pts      (pt_r),
    .err      (sb_err_r[PIPE_LAT-1]),
    .base     (sb_base_r[PIPE_LAT-1]),
    .ready    (ser_ready),
    .out_ch   (out_ch)
  );

  `UVS_NEVER(a_no_take_busy, in_ch.ready && rcp_busy, "input taken during reciprocal pass")
  `UVS_ASSERT(a_stall_held, !pipe_en |-> out_ch.valid, "stall without pending word")
  `UVS_ASSERT(a_cfg_restart, cfg_wr |=> rcp_busy, "config write did not restart pass")
endmodule

// File: dv/uvs_vertex_checker.sv
`timescale 1ns / 1ps
module uvs_vertex_checker (
  input  logic clk,
  input  logic rst_n,
  uvs_in_if    in_mon,
  uvs_out_if   out_mon,
  uvs_cfg_if   cfg_mon,
  output int   fails,
  output int   pending
);
  import uvs_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [1:0]              corner;
    logic [VN_W-1:0]         vn;
    logic                    err;
    logic                    last;
  } vertex_t;

  vertex_t        vertex_q[$];
  logic [N_W-1:0] lat_div;
  logic           dbl_lon;

  initial fails = 0;

  function automatic void sin_cos(input logic [ANG_W-1:0] a, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = longint'(CORDIC_START);
    y = 0;
    z = longint'(a[29:0]);
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[k]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[k]);
      end
    end
    case (a[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] to_fixed(input longint v);
    longint r, one;
    one = longint'(1) << FRACTION_BITS;
    r = (v + (longint'(1) << (59 - FRACTION_BITS))) >>> (60 - FRACTION_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[POS_W-1:0];
  endfunction

  function automatic logic [ANG_W-1:0] step_angle(input longint unsigned step,
                                                  input longint unsigned den);
    longint unsigned q;
    q = ((step << 32) + den / 2) / den;
    return q[ANG_W-1:0];
  endfunction

  function automatic void compare(input string name, input longint exp, input longint act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      fails++;
    end
  endfunction

  task automatic predict_cell(input longint unsigned t, input longint unsigned f);
    longint unsigned n, m, base;
    logic [ANG_W-1:0] th[2], ph[2];
    longint ct, st, cp, sp;
    vertex_t pt[4];
    vertex_t v;
    int sel[6] = '{0, 1, 2, 2, 3, 0};
    n = (lat_div > MAX_DIVISIONS) ? MAX_DIVISIONS : lat_div;
    m = dbl_lon ? 2 * n : n;
    if (n < 2 || t >= n - 1 || f >= m - 1) begin
      v = '{x: 0, y: 0, z: 0, corner: 0, vn: 0, err: 1'b1, last: 1'b1};
      vertex_q.push_back(v);
      return;
    end
    for (int i = 0; i < 2; i++) begin
      th[i] = step_angle(t + i, 2 * (n - 1));
      ph[i] = step_angle(f + i, m - 1);
    end
    // p0 (t,f), p1 (t+1,f), p2 (t+1,f+1), p3 (t,f+1)
    for (int p = 0; p < 4; p++) begin
      sin_cos(th[(p == 1 || p == 2) ? 1 : 0], ct, st);
      sin_cos(ph[(p >= 2) ? 1 : 0], cp, sp);
      pt[p].x = to_fixed(st * cp);
      pt[p].y = to_fixed(st * sp);
      pt[p].z = to_fixed(ct * (longint'(1) << 30));
    end
    base = 6 * (t * (m - 1) + f);
    for (int k = 0; k < 6; k++) begin
      v = pt[sel[k]];
      v.corner = 2'(k % 3);
      v.vn = VN_W'(base + k);
      v.err = 1'b0;
      v.last = (k == 5);
      vertex_q.push_back(v);
    end
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      lat_div = 11'd16;
      dbl_lon = 1'b0;
      vertex_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_THETA_DIVISIONS) lat_div = cfg_mon.data;
        else if (cfg_mon.index == CFG_DOUBLED_LONGITUDE) dbl_lon = cfg_mon.data[0];
      end
      if (out_mon.valid && out_mon.ready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex word with no expectation pending");
          fails++;
        end else begin
          e = vertex_q.pop_front();
          compare("pos_x", e.x, out_mon.pos_x);
          compare("pos_y", e.y, out_mon.pos_y);
          compare("pos_z", e.z, out_mon.pos_z);
          compare("corner", e.corner, out_mon.corner);
          compare("vertex_number", e.vn, out_mon.vertex_number);
          compare("range_error", e.err, out_mon.range_error);
          compare("last", e.last, out_mon.last);
        end
      end
      if (in_mon.valid && in_mon.ready) predict_cell(in_mon.theta_step, in_mon.phi_step);
    end
    pending <= vertex_q.size();
  end

endmodule

// File: dv/uv_sphere_cell_vertex_generator_core_tb.sv
`timescale 1ns / 1ps
module uv_sphere_cell_vertex_generator_core_tb;
  import uvs_pkg::*;

  localparam logic [7:0] CFG_UNUSED_IDX = 8'd2;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  bit   no_idle;
  bit   long_hold;
  int   cur_n;
  bit   cur_dbl;

  uvs_in_if  in_ch ();
  uvs_out_if out_ch ();
  uvs_cfg_if cfg_ch ();

  uv_sphere_cell_vertex_generator_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  uvs_vertex_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_mon (cfg_ch),
    .fails   (fails),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("FAIL uv_sphere_cell_vertex_generator_core");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  // receiver
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      n = draw_gap();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_cell(input int t, input int f);
    int n;
    n = draw_gap();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.theta_step <= 10'(t);
    in_ch.phi_step <= N_W'(f);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(input int count);
    int n, m;
    n = (cur_n > MAX_DIVISIONS) ? MAX_DIVISIONS : cur_n;
    m = cur_dbl ? 2 * n : n;
    repeat (count) begin
      if (n >= 2 && $urandom_range(0, 3) != 0)
        send_cell($urandom_range(0, n - 2), $urandom_range(0, m - 2));
      else
        send_cell($urandom_range(0, 1023), $urandom_range(0, 2047));
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input int d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= N_W'(d);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_THETA_DIVISIONS) cur_n = d;
    else if (idx == CFG_DOUBLED_LONGITUDE) cur_dbl = d[0];
    @(posedge clk);
  endtask

  initial begin
    no_idle = 0;
    long_hold = 0;
    cur_n = 16;
    cur_dbl = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.theta_step <= '0;
    in_ch.phi_step <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_THETA_DIVISIONS;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: N = M = 16
    send_cell(0, 0);
    send_cell(14, 14);
    send_cell(0, 14);
    send_cell(14, 0);
    send_cell(15, 0);
    send_cell(0, 15);
    send_cell(1023, 2047);
    send_cell(7, 3);
    send_random(60);
    drain();

    write_reg(CFG_THETA_DIVISIONS, 1024);
    write_reg(CFG_DOUBLED_LONGITUDE, 1);
    send_cell(0, 0);
    send_cell(1022, 2046);
    send_cell(1023, 0);
    send_cell(0, 2047);
    send_cell(1022, 0);
    send_cell(511, 1023);
    send_cell(512, 1024);
    send_cell(341, 682);
    long_hold = 1;
    send_random(80);
    drain();

    write_reg(CFG_THETA_DIVISIONS, 2);
    write_reg(CFG_DOUBLED_LONGITUDE, 0);
    send_cell(0, 0);
    send_cell(1, 0);
    send_cell(0, 1);
    send_random(30);
    drain();

    write_reg(CFG_DOUBLED_LONGITUDE, 1);
    send_cell(0, 2);
    send_cell(0, 3);
    send_random(30);
    drain();

    write_reg(CFG_THETA_DIVISIONS, 0);
    send_cell(0, 0);
    send_random(20);
    drain();

    no_idle = 1;
    write_reg(CFG_THETA_DIVISIONS, 2047);
    write_reg(CFG_DOUBLED_LONGITUDE, 0);
    send_random(60);
    drain();
    no_idle = 0;

    write_reg(CFG_UNUSED_IDX, 5);
    write_reg(CFG_THETA_DIVISIONS, 1);
    send_random(20);
    drain();

    repeat (4) begin
      write_reg(CFG_THETA_DIVISIONS, $urandom_range(3, 1024));
      write_reg(CFG_DOUBLED_LONGITUDE, $urandom_range(0, 1));
      no_idle = ($urandom_range(0, 3) == 0);
      send_random(45);
      drain();
    end

    if (fails == 0)
      $display("PASS uv_sphere_cell_vertex_generator_core");
    else
      $display("FAIL uv_sphere_cell_vertex_generator_core");
    $finish;
  end

endmodule
